// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and controller/datapath interface structs for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned DATA_W = 32;

   // operation kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_PEEK   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] priority_f;
      logic [DATA_W-1:0] value_f;
   } entry_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_COUNT,
      POS_ZERO,
      POS_DEC,
      POS_INC
   } pos_op_type;

   // read address relative to the next position
   typedef enum logic [1:0] {
      RD_AT,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   typedef enum logic {
      WR_ITEM,
      WR_SHIFT
   } wr_src_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic       latch;
      logic       status_load;
      logic [1:0] status_code;
      logic       head_clear;
      logic       head_load;
      pos_op_type pos_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_src_type wr_src;
      cnt_op_type cnt_op;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       cnt_zero;
      logic       cnt_full;
      logic       cnt_gt1;
      logic       pos_one;
      logic       shift_more;
      logic       less;
      logic       out_free;
   } stat_type;

endpackage

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the queue: dispatches one operation, steps the entry
// shifts one per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_HEAD,
      ST_REM_SHIFT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = spq_pkg::STATUS_OK;
      cmd.pos_op      = spq_pkg::POS_HOLD;
      cmd.rd_sel      = spq_pkg::RD_AT;
      cmd.wr_src      = spq_pkg::WR_ITEM;
      cmd.cnt_op      = spq_pkg::CNT_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.status_load = 1'b1;
            cmd.head_clear  = 1'b1;
            case (stat.kind)
               spq_pkg::KIND_INSERT: begin
                  if (stat.cnt_full) begin
                     cmd.status_code = spq_pkg::STATUS_FULL;
                     state_in        = ST_FINISH;
                  end else if (stat.cnt_zero) begin
                     cmd.pos_op = spq_pkg::POS_COUNT;
                     state_in   = ST_INS_PUT;
                  end else begin
                     cmd.pos_op = spq_pkg::POS_COUNT;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = spq_pkg::RD_BELOW;
                     state_in   = ST_INS_CMP;
                  end
               end
               spq_pkg::KIND_REMOVE, spq_pkg::KIND_PEEK: begin
                  if (stat.cnt_zero) begin
                     cmd.status_code = spq_pkg::STATUS_EMPTY;
                     state_in        = ST_FINISH;
                  end else begin
                     cmd.pos_op = spq_pkg::POS_ZERO;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = spq_pkg::RD_AT;
                     state_in   = ST_HEAD;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_INS_CMP: begin
            if (stat.less) begin
               // entry below moves up one slot
               cmd.wr_en  = 1'b1;
               cmd.wr_src = spq_pkg::WR_SHIFT;
               cmd.pos_op = spq_pkg::POS_DEC;
               if (stat.pos_one) begin
                  state_in = ST_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = spq_pkg::RD_BELOW;
               end
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = spq_pkg::WR_ITEM;
               cmd.cnt_op = spq_pkg::CNT_INC;
               state_in   = ST_FINISH;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = spq_pkg::WR_ITEM;
            cmd.cnt_op = spq_pkg::CNT_INC;
            state_in   = ST_FINISH;
         end
         ST_HEAD: begin
            cmd.head_load = 1'b1;
            if (stat.kind == spq_pkg::KIND_REMOVE) begin
               if (stat.cnt_gt1) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = spq_pkg::RD_ABOVE;
                  state_in   = ST_REM_SHIFT;
               end else begin
                  cmd.cnt_op = spq_pkg::CNT_DEC;
                  state_in   = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_REM_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = spq_pkg::WR_SHIFT;
            cmd.pos_op = spq_pkg::POS_INC;
            if (stat.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = spq_pkg::RD_ABOVE;
            end else begin
               cmd.cnt_op = spq_pkg::CNT_DEC;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Entry memory, count, working position, operand and result registers.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = $clog2(DEPTH),
   parameter int unsigned CW    = $clog2(DEPTH + 1),
   parameter int unsigned RSP_W = ((2 * spq_pkg::DATA_W + CW + 2 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_tuser,
   input  logic [2*spq_pkg::DATA_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_tuser,
   output logic [RSP_W-1:0]                  rsp_tdata,
   input  spq_pkg::cmd_type                  cmd,
   output spq_pkg::stat_type                 stat
);

   spq_pkg::entry_type mem [DEPTH];
   spq_pkg::entry_type rd_data_ff;
   spq_pkg::entry_type item_ff;
   spq_pkg::entry_type head_ff;
   spq_pkg::entry_type wr_data;
   logic [1:0]         kind_ff;
   logic [1:0]         status_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [AW-1:0]      pos_ff;
   logic [AW-1:0]      pos_in;
   logic [AW-1:0]      rd_addr;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   always_comb begin
      case (cmd.pos_op)
         spq_pkg::POS_COUNT: pos_in = count_ff[AW-1:0];
         spq_pkg::POS_ZERO:  pos_in = '0;
         spq_pkg::POS_DEC:   pos_in = pos_ff - AW'(1);
         spq_pkg::POS_INC:   pos_in = pos_ff + AW'(1);
         default:            pos_in = pos_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         spq_pkg::RD_BELOW: rd_addr = pos_in - AW'(1);
         spq_pkg::RD_ABOVE: rd_addr = pos_in + AW'(1);
         default:           rd_addr = pos_in;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         spq_pkg::CNT_INC: count_in = count_ff + CW'(1);
         spq_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase
   end

   assign wr_data = (cmd.wr_src == spq_pkg::WR_SHIFT) ? rd_data_ff : item_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.latch) begin
         kind_ff          <= req_tuser;
         item_ff.value_f    <= req_tdata[spq_pkg::DATA_W-1:0];
         item_ff.priority_f <= req_tdata[2*spq_pkg::DATA_W-1:spq_pkg::DATA_W];
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.head_clear) begin
         head_ff <= '0;
      end else if (cmd.head_load) begin
         head_ff <= rd_data_ff;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= RSP_W'({(count_ff == CW'(DEPTH)), (count_ff == '0), count_ff,
                                  head_ff.priority_f, head_ff.value_f});
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.cnt_zero   = (count_ff == '0);
   assign stat.cnt_full   = (count_ff == CW'(DEPTH));
   assign stat.cnt_gt1    = (count_ff > CW'(1));
   assign stat.pos_one    = (pos_ff == AW'(1));
   assign stat.shift_more = ((CW+1)'(pos_ff) + (CW+1)'(2)) < (CW+1)'(count_ff);
   assign stat.less       = $signed(rd_data_ff.priority_f) < $signed(item_ff.priority_f);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue held as a sorted entry memory, highest priority at the head.
// ----------------------------------------------------------------------------
// Request words carry an operation in req_tuser (insert, remove, peek) and
// a value and signed priority in req_tdata. Every request gives exactly one
// response word: a status in rsp_tuser and the head entry, occupancy and
// empty/full flags in rsp_tdata. An insert lands behind all entries of equal
// or higher priority, so equal priorities leave in arrival order.
// One operation is in flight at a time. The entries sit in a memory with
// one write port and one registered read port, and an insert or remove
// moves one entry per cycle. req_tready is high only between operations.
// A finished response sits in the output register; the next request is
// taken while it waits, and that request's result is held internally until
// the receiver drains the first. Reset empties the queue and drops any
// pending response word.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] kind
   input  logic [1:0]             req_tuser,
   // [31:0] item_value, [63:32] item_priority
   input  logic [63:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status
   output logic [1:0]             rsp_tuser,
   // [31:0] head_value, [63:32] head_priority, then occupancy, is_empty,
   // is_full, zero padding
   output logic [((2*spq_pkg::DATA_W+$clog2(DEPTH+1)+2+7)/8)*8-1:0] rsp_tdata
);

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
